[rtl/core/uvs_pkg.sv]
// uv sphere tile generator package: widths, sine table and phase helpers
// used by the core; no dependencies
`timescale 1ns / 1ps
package uvs_pkg;

	localparam int INDEX_BITS_DEF = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int SINE_BITS_DEF  = 10;
	localparam int Q30            = 30;

	// register indexes of the configuration port
	localparam logic [0:0] REG_LAT = 1'b0;
	localparam logic [0:0] REG_LON = 1'b1;

	localparam longint COEF0 = 64'sd1686629713;
	localparam longint COEF1 = -64'sd693598670;
	localparam longint COEF2 = 64'sd85569306;
	localparam longint COEF3 = -64'sd5026996;
	localparam longint COEF4 = 64'sd172272;
	localparam longint COEF5 = -64'sd3864;

	// floor(a*b / 2^30)
	function automatic longint mul_q30(input longint a, input longint b);
		longint p;
		p = a * b;
		if (p >= 0)
			return p >>> Q30;
		return -((-p + ((64'sd1 <<< Q30) - 1)) >>> Q30);
	endfunction

	// quarter-wave sine sample, evaluated at elaboration for the constant table
	function automatic longint quarter_sine(input longint r, input int sbits, input int frac);
		longint x;
		longint s;
		longint p;
		longint d;
		longint t;
		x = r <<< (Q30 - (sbits - 2));
		s = mul_q30(x, x);
		p = COEF5;
		p = COEF4 + mul_q30(p, s);
		p = COEF3 + mul_q30(p, s);
		p = COEF2 + mul_q30(p, s);
		p = COEF1 + mul_q30(p, s);
		p = COEF0 + mul_q30(p, s);
		p = mul_q30(p, x);
		if (p < 0)
			p = 0;
		d = 64'sd1 <<< (Q30 - frac);
		t = p + (d >>> 1);
		p = t >>> (Q30 - frac);
		if (p > (64'sd1 <<< frac))
			p = 64'sd1 <<< frac;
		return p;
	endfunction

endpackage

[rtl/core/uv_sphere_tile_generator_core.sv]
// uv sphere tile generator core: tile request in, six vertices out
// depends on uvs_pkg
`timescale 1ns / 1ps
// Usage:
//   s_axis: one request per tile, tdata = band_index (low), wedge_index.
//   m_axis: six vertices per tile (TL,BL,BR,TL,BR,TR), tdata = pos_x, pos_y,
//     pos_z, norm_x, norm_y, norm_z from the lowest bit up; tlast marks the
//     sixth vertex (last_vertex).
//   cfg: cfg_we/cfg_addr/cfg_wdata write lat_segments (0) and lon_segments (1);
//     write only while the block is idle.
// Throughput: one vertex per cycle while the output is taken; the stage-2
//   vertex sequencer holds a tile until its sixth step and takes the next request
//   on that step, so requests can follow back to back with no gap.
// Pipeline: a request passes the stages clamp, vertex select, two halves of
//   the phase division, sine table and products; rounding feeds the output
//   register, and the remaining vertices of the tile follow it in order.
// Reset: registers return to lat 1, lon 3 and the pipeline empties.
// Stall: every stage holds while the output register is full and not taken;
//   nothing is dropped or repeated.
module uv_sphere_tile_generator_core #(
	parameter int INDEX_BITS      = uvs_pkg::INDEX_BITS_DEF,
	parameter int COORD_BITS      = uvs_pkg::COORD_BITS_DEF,
	parameter int SINE_TABLE_BITS = uvs_pkg::SINE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_addr,
	input  logic [INDEX_BITS-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// band_index, wedge_index from the lowest bit up
	input  logic [2*INDEX_BITS-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from the lowest bit up
	output logic [6*COORD_BITS-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	localparam int FRAC  = COORD_BITS - 2;
	localparam int P     = 1 << SINE_TABLE_BITS;
	localparam int QTR   = P / 4;
	localparam int SB    = SINE_TABLE_BITS;
	localparam int NUMW  = INDEX_BITS + SB + 2;
	localparam int SW    = FRAC + 2;
	localparam int LO    = (SB + 1) / 2;

	typedef logic signed [SW-1:0] samp_t;

	typedef struct packed {
		logic [NUMW-1:0] rem;
		logic [SB:0]     q;
	} dstep_t;

	// quarter-wave table, constant logic built at elaboration
	samp_t qtab [QTR+1];
	for (genvar g = 0; g <= QTR; g++) begin : g_qtab
		localparam samp_t QV = samp_t'(uvs_pkg::quarter_sine(longint'(g), SB, FRAC));
		assign qtab[g] = QV;
	end

	function automatic samp_t tsin(input logic [SB-1:0] k);
		logic [SB-3:0] r;
		logic [SB-2:0] rr;
		samp_t v;
		r  = k[SB-3:0];
		rr = k[SB-2] ? (SB-1)'(QTR) - {1'b0, r} : {1'b0, r};
		v  = qtab[rr];
		return k[SB-1] ? -v : v;
	endfunction

	// restoring division steps for quotient bits hi down to lo
	function automatic dstep_t div_part(input dstep_t a, input logic [INDEX_BITS:0] d,
		input int hi, input int lo);
		dstep_t r;
		r = a;
		for (int i = SB; i >= 0; i--) begin
			if (i <= hi && i >= lo && r.rem >= (NUMW'(d) << i)) begin
				r.rem  = r.rem - (NUMW'(d) << i);
				r.q[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// configuration registers
	logic [INDEX_BITS-1:0] lat_q, lon_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= INDEX_BITS'(1);
			lon_q <= INDEX_BITS'(3);
		end else if (cfg_we) begin
			if (cfg_addr == uvs_pkg::REG_LAT)
				lat_q <= cfg_wdata;
			else if (cfg_addr == uvs_pkg::REG_LON)
				lon_q <= cfg_wdata;
		end
	end

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [2:0] cnt_q;
	logic busy_s2_last;

	// stage 1: clamp counts and indices, form numerators and divisors
	logic [INDEX_BITS-1:0] lat_c, lon_c, b_c, w_c;
	logic [NUMW-1:0] n0_s1, n1_s1, n2_s1, n3_s1;
	logic [INDEX_BITS:0] dl_s1, dn_s1;
	always_comb begin
		lat_c = (lat_q < INDEX_BITS'(1)) ? INDEX_BITS'(1) : lat_q;
		lon_c = (lon_q < INDEX_BITS'(3)) ? INDEX_BITS'(3) : lon_q;
		b_c   = (s_axis_tdata[INDEX_BITS-1:0] > lat_c - 1'b1) ? lat_c - 1'b1
		        : s_axis_tdata[INDEX_BITS-1:0];
		w_c   = (s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS] > lon_c - 1'b1) ? lon_c - 1'b1
		        : s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
	end

	// the stage-2 sequencer holds a tile until its sixth step, when the next one enters
	assign s_axis_tready = adv && (!v_s1 || busy_s2_last);
	wire s_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv) begin
			if (s_acc)
				v_s1 <= 1'b1;
			else if (busy_s2_last)
				v_s1 <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (s_acc) begin
			n0_s1 <= NUMW'(b_c) * NUMW'(P) + NUMW'(lat_c);
			n1_s1 <= (NUMW'(b_c) + 1'b1) * NUMW'(P) + NUMW'(lat_c);
			n2_s1 <= NUMW'(w_c) * NUMW'(2 * P) + NUMW'(lon_c);
			n3_s1 <= (NUMW'(w_c) + 1'b1) * NUMW'(2 * P) + NUMW'(lon_c);
			dl_s1 <= {lat_c, 1'b0};
			dn_s1 <= {lon_c, 1'b0};
		end
	end

	// stage 2: vertex sequencer picks one (phi, theta) pair per cycle unless stalled
	logic [NUMW-1:0] np_s2, nt_s2;
	logic [INDEX_BITS:0] dp_s2, dt_s2;
	logic last_s2;
	assign busy_s2_last = (cnt_q == 3'd5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			v_s2  <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s1)
				cnt_q <= busy_s2_last ? 3'd0 : cnt_q + 3'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			np_s2   <= (cnt_q == 3'd1 || cnt_q == 3'd2 || cnt_q == 3'd4) ? n1_s1 : n0_s1;
			nt_s2   <= (cnt_q == 3'd2 || cnt_q == 3'd4 || cnt_q == 3'd5) ? n3_s1 : n2_s1;
			dp_s2   <= dl_s1;
			dt_s2   <= dn_s1;
			last_s2 <= busy_s2_last;
		end
	end

	// stage 3: upper quotient bits of the phase division
	// quotient never exceeds P, so SB+1 quotient bits suffice
	dstep_t qp_s3, qt_s3;
	logic [INDEX_BITS:0] dp_s3, dt_s3;
	logic last_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			qp_s3   <= div_part(dstep_t'({np_s2, (SB+1)'(0)}), dp_s2, SB, LO);
			qt_s3   <= div_part(dstep_t'({nt_s2, (SB+1)'(0)}), dt_s2, SB, LO);
			dp_s3   <= dp_s2;
			dt_s3   <= dt_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 4: lower quotient bits
	dstep_t qp_fin, qt_fin;
	logic [SB:0] pp_s4, pt_s4;
	logic last_s4;
	always_comb begin
		qp_fin = div_part(qp_s3, dp_s3, LO - 1, 0);
		qt_fin = div_part(qt_s3, dt_s3, LO - 1, 0);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_s4   <= qp_fin.q;
			pt_s4   <= qt_fin.q;
			last_s4 <= last_s3;
		end
	end

	// stage 5: sine table lookups
	samp_t sp_s5, cp_s5, st_s5, ct_s5;
	logic last_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s5   <= tsin(pp_s4[SB-1:0]);
			cp_s5   <= tsin(pp_s4[SB-1:0] + SB'(QTR));
			st_s5   <= tsin(pt_s4[SB-1:0]);
			ct_s5   <= tsin(pt_s4[SB-1:0] + SB'(QTR));
			last_s5 <= last_s4;
		end
	end

	// stage 6: products
	logic signed [2*SW-1:0] px_s6, pz_s6;
	samp_t cp_s6;
	logic last_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s6   <= sp_s5 * ct_s5;
			pz_s6   <= -(sp_s5 * st_s5);
			cp_s6   <= cp_s5;
			last_s6 <= last_s5;
		end
	end

	// output register: round half up and pack
	logic signed [2*SW-1:0] rx, rz;
	logic signed [SW-1:0] ry;
	logic [COORD_BITS-1:0] ox, oy, oz;
	always_comb begin
		rx = (px_s6 + (2*SW)'(1 << FRAC)) >>> (FRAC + 1);
		rz = (pz_s6 + (2*SW)'(1 << FRAC)) >>> (FRAC + 1);
		ry = (cp_s6 + SW'(1)) >>> 1;
		ox = rx[COORD_BITS-1:0];
		oy = COORD_BITS'(ry);
		oz = rz[COORD_BITS-1:0];
	end

	assign adv = !m_axis_tvalid || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (adv)
			m_axis_tvalid <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {oz << 1, oy << 1, ox << 1, oz, oy, ox};
			m_axis_tlast <= last_s6;
		end
	end

	// a new request only enters while the sequencer is free or on its last step
	a_seq_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> (!v_s1 || busy_s2_last))
		else $error("request taken mid-tile");
	// last vertex flag follows the sixth sequencer step
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && busy_s2_last) |=> last_s2)
		else $error("last flag lost");
	// counter only runs while a tile is held
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> (cnt_q == 3'd0))
		else $error("counter runs with no tile");

endmodule

[tb/uv_sphere_tile_generator_core_test.sv]
// testbench for the uv sphere tile generator core: directed table, then random tiles
// checked against an in-bench vertex predictor; depends on uvs_pkg and the core
`timescale 1ns / 1ps
module uv_sphere_tile_generator_core_test;

	localparam int IB = uvs_pkg::INDEX_BITS_DEF;
	localparam int CB = uvs_pkg::COORD_BITS_DEF;
	localparam int SB = uvs_pkg::SINE_BITS_DEF;
	localparam int FR = CB - 2;
	localparam int FULL = 1 << SB;
	localparam int QTR = 1 << (SB - 2);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [CB-1:0] nz, ny, nx, pz, py, px;
	} vertex_t;

	typedef struct {
		vertex_t v;
		bit      last;
	} vertex_exp_t;

	typedef enum bit {ROW_TILE, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t kind;
		bit [IB-1:0] a;    // band, or lat count
		bit [IB-1:0] b;    // wedge, or lon count
		bit top_pole;      // first vertex sits at the top pole
	} row_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [0:0] cfg_addr;
	logic [IB-1:0] cfg_wdata;
	logic s_axis_tvalid, s_axis_tready;
	// band_index, wedge_index from the lowest bit up
	logic [2*IB-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from the lowest bit up
	logic [6*CB-1:0] m_axis_tdata;
	logic m_axis_tlast;

	uv_sphere_tile_generator_core dut (.*);

	longint sine_lut [FULL];
	int lat_count, lon_count;
	vertex_exp_t vertex_q [$];
	int mismatches, tiles_sent, vertices_seen, cycles, hold_left;
	bit hold_done, quiet;

	row_t rows [] = '{
		'{ROW_TILE, 0, 0, 1}, '{ROW_TILE, 0, 2, 1}, '{ROW_TILE, 255, 255, 0},
		'{ROW_CFG, 0, 0, 0}, '{ROW_TILE, 0, 0, 1}, '{ROW_TILE, 7, 9, 0},
		'{ROW_CFG, 255, 255, 0}, '{ROW_TILE, 0, 0, 1}, '{ROW_TILE, 254, 254, 0},
		'{ROW_TILE, 255, 255, 0}, '{ROW_TILE, 128, 64, 0}, '{ROW_TILE, 0, 255, 1},
		'{ROW_CFG, 2, 4, 0}, '{ROW_TILE, 1, 3, 0}, '{ROW_TILE, 0, 1, 1},
		'{ROW_TILE, 200, 200, 0}, '{ROW_CFG, 4, 3, 0}, '{ROW_TILE, 3, 2, 0},
		'{ROW_TILE, 1, 1, 0}, '{ROW_CFG, 1, 255, 0}, '{ROW_TILE, 0, 128, 1}
	};

	// quarter-wave polynomial in q30, floored products
	function automatic longint quarter_wave(int r);
		longint x, s, p;
		longint coef [6] = '{uvs_pkg::COEF0, uvs_pkg::COEF1, uvs_pkg::COEF2,
			uvs_pkg::COEF3, uvs_pkg::COEF4, uvs_pkg::COEF5};
		x = longint'(r) <<< (uvs_pkg::Q30 - (SB - 2));
		s = (x * x) >>> uvs_pkg::Q30;
		p = coef[5];
		for (int i = 4; i >= 0; i--)
			p = coef[i] + ((p * s) >>> uvs_pkg::Q30);
		p = (p * x) >>> uvs_pkg::Q30;
		if (p < 0)
			p = 0;
		p = (p + (64'sd1 <<< (uvs_pkg::Q30 - FR - 1))) >>> (uvs_pkg::Q30 - FR);
		if (p > (64'sd1 <<< FR))
			p = 64'sd1 <<< FR;
		return p;
	endfunction

	function automatic vertex_t vertex_at(int pphi, int ptheta);
		longint sp, cp, st, ct, px, py, pz;
		vertex_t v;
		sp = sine_lut[pphi % FULL];
		cp = sine_lut[(pphi + QTR) % FULL];
		st = sine_lut[ptheta % FULL];
		ct = sine_lut[(ptheta + QTR) % FULL];
		px = (sp * ct + (64'sd1 <<< FR)) >>> (FR + 1);
		py = (cp + 1) >>> 1;
		pz = (-(sp * st) + (64'sd1 <<< FR)) >>> (FR + 1);
		v.px = CB'(px); v.py = CB'(py); v.pz = CB'(pz);
		v.nx = CB'(px * 2); v.ny = CB'(py * 2); v.nz = CB'(pz * 2);
		return v;
	endfunction

	// six vertices of one tile, in triangle order
	task automatic predict_tile(int band, int wedge, bit top_pole);
		int lat, lon, b, w, phi0, phi1, th0, th1;
		vertex_t tl;
		lat = (lat_count < 1) ? 1 : lat_count;
		lon = (lon_count < 3) ? 3 : lon_count;
		b = (band > lat - 1) ? lat - 1 : band;
		w = (wedge > lon - 1) ? lon - 1 : wedge;
		phi0 = (b * FULL + lat) / (2 * lat);
		phi1 = ((b + 1) * FULL + lat) / (2 * lat);
		th0 = ((2 * w * FULL + lon) / (2 * lon)) % FULL;
		th1 = ((2 * (w + 1) * FULL + lon) / (2 * lon)) % FULL;
		tl = vertex_at(phi0, th0);
		// top pole: straight up, half radius
		if (top_pole)
			tl = '{nz: 0, ny: 16'sd16384, nx: 0, pz: 0, py: 16'sd8192, px: 0};
		vertex_q.push_back('{tl, 0});
		vertex_q.push_back('{vertex_at(phi1, th0), 0});
		vertex_q.push_back('{vertex_at(phi1, th1), 0});
		vertex_q.push_back('{tl, 0});
		vertex_q.push_back('{vertex_at(phi1, th1), 0});
		vertex_q.push_back('{vertex_at(phi0, th1), 1});
	endtask

	// offer one request, hold it until taken
	task automatic send_tile(int band, int wedge, bit top_pole);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {wedge[IB-1:0], band[IB-1:0]};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		predict_tile(band, wedge, top_pole);
		tiles_sent++;
		if (!quiet && $urandom_range(0, 99) < 30) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for outstanding vertices, then write both counts
	task automatic set_counts(int lat, int lon);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (vertex_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= uvs_pkg::REG_LAT;
		cfg_wdata <= IB'(lat);
		@(posedge clk);
		cfg_addr <= uvs_pkg::REG_LON;
		cfg_wdata <= IB'(lon);
		@(posedge clk);
		cfg_we <= 1'b0;
		lat_count = lat;
		lon_count = lon;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random idling, one long hold-off, a quiet window
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && tiles_sent == 40) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= quiet || ($urandom_range(0, 99) >= 30);
	end

	// vertex checker
	always @(posedge clk) begin
		vertex_exp_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			vertices_seen++;
			if (vertex_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected vertex %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				e = vertex_q.pop_front();
				if (m_axis_tdata !== e.v || m_axis_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("vertex %0d: expected %h last %b, got %h last %b",
							vertices_seen, e.v, e.last, m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d vertices outstanding", vertex_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int lat, lon, band, wedge;
		for (int k = 0; k < FULL; k++) begin
			if ((k / QTR) % 2 == 1)
				sine_lut[k] = quarter_wave(QTR - k % QTR);
			else
				sine_lut[k] = quarter_wave(k % QTR);
			if ((k / QTR) >= 2)
				sine_lut[k] = -sine_lut[k];
		end
		mismatches = 0; tiles_sent = 0; vertices_seen = 0; cycles = 0;
		hold_left = 0; hold_done = 0; quiet = 0;
		lat_count = 1; lon_count = 3;
		cfg_we = 0; cfg_addr = uvs_pkg::REG_LAT; cfg_wdata = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; m_axis_tready = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				set_counts(rows[i].a, rows[i].b);
			else
				send_tile(rows[i].a, rows[i].b, rows[i].top_pole);
		end

		// random phases, each with fresh counts
		for (int ph = 0; ph < 5; ph++) begin
			lat = ($urandom_range(0, 1)) ? $urandom_range(0, 8) : $urandom_range(0, 255);
			lon = ($urandom_range(0, 1)) ? $urandom_range(0, 8) : $urandom_range(0, 255);
			set_counts(lat, lon);
			if (lat < 1) lat = 1;
			if (lon < 3) lon = 3;
			for (int n = 0; n < 19; n++) begin
				quiet = (tiles_sent >= 70 && tiles_sent < 95);
				if ($urandom_range(0, 99) < 75) begin
					band = $urandom_range(0, lat - 1);
					wedge = $urandom_range(0, lon - 1);
				end else begin
					band = $urandom_range(0, 255);
					wedge = $urandom_range(0, 255);
				end
				send_tile(band, wedge, 0);
			end
		end
		s_axis_tvalid <= 1'b0;
		quiet = 1;

		while (vertex_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d tiles, %0d vertices, across several band and wedge counts",
			tiles_sent, vertices_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/uvs_pkg.sv
rtl/core/uv_sphere_tile_generator_core.sv
tb/uv_sphere_tile_generator_core_test.sv
